>>> design/kscd_pkg.sv
// Shared types, constants and scan code tables for the keyboard scan code decoder.
package kscd_pkg;

  // Default depth of the keyboard command queue.
  localparam int unsigned CmdQueueDepthDefault = 8;

  // Keyboard command and response bytes.
  localparam logic [7:0] LedCmd     = 8'hED;
  localparam logic [7:0] AckByte    = 8'hFA;
  localparam logic [7:0] ResendByte = 8'hFE;

  // Scan codes with a special meaning.
  localparam logic [7:0] LShiftMake  = 8'h2A;
  localparam logic [7:0] RShiftMake  = 8'h36;
  localparam logic [7:0] LShiftBreak = 8'hAA;
  localparam logic [7:0] RShiftBreak = 8'hB6;
  localparam logic [7:0] CapsMake    = 8'h3A;
  localparam logic [7:0] ScrollMake  = 8'h45;

  // Offset from an upper case to a lower case letter.
  localparam logic [6:0] LowerOffset = 7'h20;
  localparam logic [6:0] UpperFirst  = 7'h41;
  localparam logic [6:0] UpperLast   = 7'h5A;

  // LED bit positions.
  localparam int unsigned LedScrollBit = 0;
  localparam int unsigned LedCapsBit   = 2;

  // Input action codes.
  typedef enum logic {
    ACT_BYTE = 1'b0,
    ACT_SYNC = 1'b1
  } action_e;

  // One result beat.
  typedef struct packed {
    logic       char_valid;
    logic [6:0] char_code;
    logic       send_valid;
    logic [7:0] send_byte;
    logic       queue_overflow;
    logic [2:0] led_bits;
  } result_t;

  // Status that the control block reports for the current beat.
  typedef struct packed {
    logic       send_valid;
    logic [7:0] send_byte;
    logic       queue_overflow;
    logic [2:0] led_bits;
  } ctrl_status_t;

  // Modifier state that the character lookup needs.
  typedef struct packed {
    logic shift_active;
    logic caps_lock;
  } modifier_t;

  // Unshifted layout table for make codes below 0x80.
  function automatic logic [6:0] plain_char(input logic [6:0] code);
    logic [6:0] ch;
    ch = 7'h00;
    case (code)
      7'h02: ch = 7'h31;
      7'h03: ch = 7'h32;
      7'h04: ch = 7'h33;
      7'h05: ch = 7'h34;
      7'h06: ch = 7'h35;
      7'h07: ch = 7'h36;
      7'h08: ch = 7'h37;
      7'h09: ch = 7'h38;
      7'h0A: ch = 7'h39;
      7'h0B: ch = 7'h30;
      7'h0C: ch = 7'h2D;
      7'h0D: ch = 7'h5E;
      7'h0E: ch = 7'h08;
      7'h10: ch = 7'h51;
      7'h11: ch = 7'h57;
      7'h12: ch = 7'h45;
      7'h13: ch = 7'h52;
      7'h14: ch = 7'h54;
      7'h15: ch = 7'h59;
      7'h16: ch = 7'h55;
      7'h17: ch = 7'h49;
      7'h18: ch = 7'h4F;
      7'h19: ch = 7'h50;
      7'h1A: ch = 7'h40;
      7'h1B: ch = 7'h5B;
      7'h1C: ch = 7'h0A;
      7'h1E: ch = 7'h41;
      7'h1F: ch = 7'h53;
      7'h20: ch = 7'h44;
      7'h21: ch = 7'h46;
      7'h22: ch = 7'h47;
      7'h23: ch = 7'h48;
      7'h24: ch = 7'h4A;
      7'h25: ch = 7'h4B;
      7'h26: ch = 7'h4C;
      7'h27: ch = 7'h3B;
      7'h28: ch = 7'h3A;
      7'h2B: ch = 7'h5D;
      7'h2C: ch = 7'h5A;
      7'h2D: ch = 7'h58;
      7'h2E: ch = 7'h43;
      7'h2F: ch = 7'h56;
      7'h30: ch = 7'h42;
      7'h31: ch = 7'h4E;
      7'h32: ch = 7'h4D;
      7'h33: ch = 7'h2C;
      7'h34: ch = 7'h2E;
      7'h35: ch = 7'h2F;
      7'h37: ch = 7'h2A;
      7'h39: ch = 7'h20;
      7'h47: ch = 7'h37;
      7'h48: ch = 7'h38;
      7'h49: ch = 7'h39;
      7'h4A: ch = 7'h2D;
      7'h4B: ch = 7'h34;
      7'h4C: ch = 7'h35;
      7'h4D: ch = 7'h36;
      7'h4E: ch = 7'h2B;
      7'h4F: ch = 7'h31;
      7'h50: ch = 7'h32;
      7'h51: ch = 7'h33;
      7'h52: ch = 7'h30;
      7'h53: ch = 7'h2E;
      7'h73: ch = 7'h5C;
      7'h7D: ch = 7'h5C;
      default: ch = 7'h00;
    endcase
    return ch;
  endfunction

  // Shifted layout table: only the keys that differ from the plain table.
  function automatic logic [6:0] shifted_char(input logic [6:0] code);
    logic [6:0] ch;
    ch = 7'h00;
    case (code)
      7'h02: ch = 7'h21;
      7'h03: ch = 7'h22;
      7'h04: ch = 7'h23;
      7'h05: ch = 7'h24;
      7'h06: ch = 7'h25;
      7'h07: ch = 7'h26;
      7'h08: ch = 7'h27;
      7'h09: ch = 7'h28;
      7'h0A: ch = 7'h29;
      7'h0B: ch = 7'h7E;
      7'h0C: ch = 7'h3D;
      7'h0D: ch = 7'h7E;
      7'h1A: ch = 7'h60;
      7'h1B: ch = 7'h7B;
      7'h27: ch = 7'h2B;
      7'h28: ch = 7'h2A;
      7'h2B: ch = 7'h7D;
      7'h33: ch = 7'h3C;
      7'h34: ch = 7'h3E;
      7'h35: ch = 7'h3F;
      7'h73: ch = 7'h5F;
      7'h7D: ch = 7'h7C;
      default: ch = plain_char(code);
    endcase
    return ch;
  endfunction

endpackage

>>> design/kscd_char.sv
// Character lookup: scan code to ASCII with shift and caps lock handling.
module kscd_char
  import kscd_pkg::*;
(
  input  logic       is_byte_i,
  input  logic [7:0] scan_byte_i,
  input  modifier_t  mods_i,
  output logic       char_valid_o,
  output logic [6:0] char_code_o
);

  logic [6:0] raw_ch;
  logic       is_upper;
  logic [6:0] ch;

  // Table lookup for make codes; break codes and sync beats give nothing.
  always_comb begin
    raw_ch = 7'h00;
    if (is_byte_i && !scan_byte_i[7]) begin
      raw_ch = mods_i.shift_active ? shifted_char(scan_byte_i[6:0])
                                   : plain_char(scan_byte_i[6:0]);
    end
    is_upper = (raw_ch >= UpperFirst) && (raw_ch <= UpperLast);
    // Letters stay upper case only when exactly one of caps and shift is on.
    ch = (is_upper && (mods_i.caps_lock == mods_i.shift_active)) ? raw_ch + LowerOffset
                                                                 : raw_ch;
  end

  assign char_valid_o = (ch != 7'h00);
  assign char_code_o  = ch;

endmodule

>>> design/kscd_ctrl.sv
// Control state: shift and lock tracking, LED command queue and send handshake.
module kscd_ctrl
  import kscd_pkg::*;
#(
  parameter int unsigned CMD_QUEUE_DEPTH = CmdQueueDepthDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_wdata_i,
  input  logic         accept_i,
  input  action_e      action_i,
  input  logic [7:0]   scan_byte_i,
  output modifier_t    mods_o,
  output ctrl_status_t status_o
);

  localparam int unsigned IW = (CMD_QUEUE_DEPTH > 1) ? $clog2(CMD_QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(CMD_QUEUE_DEPTH + 1);
  localparam logic [CW:0]   DepthW   = (CW + 1)'(CMD_QUEUE_DEPTH);
  localparam logic [IW-1:0] LastSlot = IW'(CMD_QUEUE_DEPTH - 1);

  logic [2:0]    init_leds_q;
  logic [1:0]    shift_q, shift_d;
  logic [2:0]    leds_q, leds_d;
  logic          ack_q, ack_d;
  logic [7:0]    last_q, last_d;
  logic [IW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic [7:0]    queue_q [CMD_QUEUE_DEPTH];

  logic          is_byte;
  logic          push_pair;
  logic          room0, room1;
  logic          push0, push1;
  logic [CW:0]   sum0, sum1;
  logic [CW:0]   slot0_w, slot1_w;
  logic [IW-1:0] slot0, slot1;
  logic [CW-1:0] count_push;
  logic          ack_mid;
  logic          resend;
  logic          pop;
  logic [7:0]    head_byte;
  logic [7:0]    led_byte;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_leds_q <= 3'd0;
    end else if (cfg_we_i) begin
      init_leds_q <= cfg_wdata_i;
    end
  end

  // Next state for one beat.
  always_comb begin
    is_byte = (action_i == ACT_BYTE);
    shift_d = shift_q;
    leds_d  = leds_q;
    if (!is_byte) begin
      leds_d = init_leds_q;
    end else begin
      case (scan_byte_i)
        LShiftMake:  shift_d = shift_q | 2'b01;
        RShiftMake:  shift_d = shift_q | 2'b10;
        LShiftBreak: shift_d = shift_q & 2'b10;
        RShiftBreak: shift_d = shift_q & 2'b01;
        CapsMake:    leds_d[LedCapsBit] = ~leds_q[LedCapsBit];
        ScrollMake:  leds_d[LedScrollBit] = ~leds_q[LedScrollBit];
        default:     ;
      endcase
    end
    push_pair = !is_byte || (scan_byte_i == CapsMake) || (scan_byte_i == ScrollMake);
    led_byte  = {5'd0, leds_d};

    // Room for the command byte and the LED byte; a full queue drops the rest.
    room0 = ({1'b0, count_q} < DepthW);
    room1 = ({1'b0, count_q} + (CW + 1)'(1) < DepthW);
    push0 = push_pair && room0;
    push1 = push_pair && room1;

    // Ring slots behind the head for the two pushes.
    sum0    = (CW + 1)'(head_q) + (CW + 1)'(count_q);
    sum1    = sum0 + (CW + 1)'(1);
    slot0_w = (sum0 >= DepthW) ? sum0 - DepthW : sum0;
    slot1_w = (sum1 >= DepthW) ? sum1 - DepthW : sum1;
    slot0   = slot0_w[IW-1:0];
    slot1   = slot1_w[IW-1:0];
    count_push = count_q + CW'(push0) + CW'(push1);

    // Acknowledge and resend from the keyboard.
    ack_mid = ack_q && !(is_byte && (scan_byte_i == AckByte));
    resend  = is_byte && (scan_byte_i == ResendByte) && ack_q;

    // Send the head byte when nothing is outstanding; an empty queue that was
    // just filled sends the LED command byte pushed in this beat.
    pop       = !resend && !ack_mid && (count_push != '0);
    head_byte = (count_q == '0) ? LedCmd : queue_q[head_q];

    head_d  = pop ? ((head_q == LastSlot) ? '0 : head_q + IW'(1)) : head_q;
    count_d = count_push - CW'(pop);
    ack_d   = pop ? 1'b1 : ack_mid;
    last_d  = pop ? head_byte : last_q;

    status_o.send_valid     = resend || pop;
    status_o.send_byte      = resend ? last_q : (pop ? head_byte : 8'd0);
    status_o.queue_overflow = push_pair && !room1;
    status_o.led_bits       = leds_d;
  end

  assign mods_o.shift_active = (shift_q != 2'b00);
  assign mods_o.caps_lock    = leds_q[LedCapsBit];

  // Control state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= 2'b00;
      leds_q  <= 3'd0;
      ack_q   <= 1'b0;
      last_q  <= 8'd0;
      head_q  <= '0;
      count_q <= '0;
    end else if (accept_i) begin
      shift_q <= shift_d;
      leds_q  <= leds_d;
      ack_q   <= ack_d;
      last_q  <= last_d;
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  // Queue storage; entries are read only after they were written.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < CMD_QUEUE_DEPTH; i++) begin
      if (accept_i && push0 && (slot0 == IW'(i))) begin
        queue_q[i] <= LedCmd;
      end else if (accept_i && push1 && (slot1 == IW'(i))) begin
        queue_q[i] <= led_byte;
      end
    end
  end

endmodule

>>> design/kscd_outbuf.sv
// Two-entry output buffer: result register plus skid register.
module kscd_outbuf
  import kscd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t data_i,
  output logic    full_o,
  output logic    valid_o,
  input  logic    stall_i,
  output result_t data_o
);

  logic    main_vld_q;
  logic    skid_vld_q;
  result_t main_q;
  result_t skid_q;
  logic    pop;

  assign pop = main_vld_q && !stall_i;

  // Valid bits: the skid register fills only when the result register is held.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (pop) begin
        skid_vld_q <= 1'b0;
      end
    end else if (push_i) begin
      if (main_vld_q && !pop) begin
        skid_vld_q <= 1'b1;
      end else begin
        main_vld_q <= 1'b1;
      end
    end else if (pop) begin
      main_vld_q <= 1'b0;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (pop) begin
        main_q <= skid_q;
      end
    end else if (push_i) begin
      if (main_vld_q && !pop) begin
        skid_q <= data_i;
      end else begin
        main_q <= data_i;
      end
    end
  end

  assign full_o  = skid_vld_q;
  assign valid_o = main_vld_q;
  assign data_o  = main_q;

endmodule

>>> design/keyboard_scan_code_decoder_core.sv
// Top level of the keyboard scan code decoder core.
// Takes one keyboard byte or sync beat per cycle while not stalled and returns exactly one
// result beat for each (character, keyboard command byte, overflow flag and LED bits). State is
// updated in the cycle an input beat is accepted, and the result is registered with it, in the
// result register or, while that is held, in the skid register, so the input keeps flowing for
// one extra beat while the output is stalled. The input stalls only while both output registers
// hold results. The LED command queue is CMD_QUEUE_DEPTH entries of flip-flops and needs no
// clearing after reset.
module keyboard_scan_code_decoder_core
  import kscd_pkg::*;
#(
  parameter int unsigned CMD_QUEUE_DEPTH = CmdQueueDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       action_i,
  input  logic [7:0] scan_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       char_valid_o,
  output logic [6:0] char_code_o,
  output logic       send_valid_o,
  output logic [7:0] send_byte_o,
  output logic       queue_overflow_o,
  output logic [2:0] led_bits_o
);

  logic         accept;
  logic         buf_full;
  action_e      action;
  modifier_t    mods;
  ctrl_status_t status;
  logic         ch_valid;
  logic [6:0]   ch_code;
  result_t      result;
  result_t      out_data;

  assign accept     = in_valid_i && !buf_full;
  assign in_stall_o = buf_full;
  assign action     = action_e'(action_i);

  // Character decode from the pre-beat modifier state.
  kscd_char u_char (
    .is_byte_i    (action == ACT_BYTE),
    .scan_byte_i  (scan_byte_i),
    .mods_i       (mods),
    .char_valid_o (ch_valid),
    .char_code_o  (ch_code)
  );

  // Lock, shift and command queue state.
  kscd_ctrl #(
    .CMD_QUEUE_DEPTH (CMD_QUEUE_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .action_i    (action),
    .scan_byte_i (scan_byte_i),
    .mods_o      (mods),
    .status_o    (status)
  );

  // Assemble the result beat.
  always_comb begin
    result.char_valid     = ch_valid;
    result.char_code      = ch_code;
    result.send_valid     = status.send_valid;
    result.send_byte      = status.send_byte;
    result.queue_overflow = status.queue_overflow;
    result.led_bits       = status.led_bits;
  end

  kscd_outbuf u_outbuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (result),
    .full_o  (buf_full),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (out_data)
  );

  assign char_valid_o     = out_data.char_valid;
  assign char_code_o      = out_data.char_code;
  assign send_valid_o     = out_data.send_valid;
  assign send_byte_o      = out_data.send_byte;
  assign queue_overflow_o = out_data.queue_overflow;
  assign led_bits_o       = out_data.led_bits;

endmodule
